>>> hdl/cdd_pkg.sv
// Shared types, constants and helper functions of the countdown digit block.
// Used by the front, the queue and the back pipeline; has no dependencies.
package cdd_pkg;

  localparam int unsigned TimeW = 32;

  localparam logic [31:0] RefreshMs = 32'd1000;
  localparam logic [31:0] BlinkMs   = 32'd500;
  localparam logic [31:0] SyncMin   = 32'd100000;

  localparam logic [16:0] DaySec  = 17'd86400;
  localparam logic [11:0] HourSec = 12'd3600;
  localparam logic [5:0]  MinSec  = 6'd60;
  localparam logic [6:0]  DaysMax = 7'd99;

  // Reciprocals: days from left>>7 (divide by 675), hours from a 17-bit
  // remainder, minutes from a 12-bit remainder. Each is exact on its range.
  localparam int unsigned DayShift  = 35;
  localparam logic [25:0] DayRecip  = 26'd50903317;
  localparam int unsigned HourShift = 29;
  localparam logic [17:0] HourRecip = 18'd149131;
  localparam int unsigned MinShift  = 18;
  localparam logic [12:0] MinRecip  = 13'd4370;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // One refresh that the back pipeline turns into digits
  typedef struct packed {
    logic [TimeW-1:0] left;
    logic             zero;
    logic             shown;
  } item_t;

  typedef struct packed {
    logic [3:0] seconds_units;
    logic [2:0] seconds_tens;
    logic [3:0] minutes_units;
    logic [2:0] minutes_tens;
    logic [3:0] hours_units;
    logic [1:0] hours_tens;
    logic [3:0] days_units;
    logic [3:0] days_tens;
  } digits_t;

  // Tens digit of a value below 100: multiply by 205/2048
  function automatic logic [3:0] tens_of(input logic [6:0] v);
    logic [14:0] p;
    p = 15'(v) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] units_of(input logic [6:0] v, input logic [3:0] t);
    logic [6:0] t10;
    t10 = 7'({t, 3'b000}) + 7'({t, 1'b0});
    return 4'(v - t10);
  endfunction

endpackage

>>> hdl/cdd_front.sv
// Front end: accepts ticks, keeps the refresh and blink state and the target.
// Emits one classified refresh item per due, synced tick. Depends on cdd_pkg.
module cdd_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  input  logic [31:0]         now_ms,
  input  logic [31:0]         current_time,
  input  logic                in_ready,
  output logic                push,
  output cdd_pkg::item_t      push_item
);

  logic [31:0] target_time;
  logic [31:0] last_refresh_ms;
  logic [31:0] last_blink_ms;
  logic        blink_on;

  logic        accept;
  logic        due;
  logic        synced;
  logic        zero;
  logic        blink_flip;
  logic        blink_on_next;
  logic [31:0] refresh_gap;
  logic [31:0] blink_gap;

  always_comb begin
    accept        = in_valid && in_ready;
    refresh_gap   = now_ms - last_refresh_ms;
    blink_gap     = now_ms - last_blink_ms;
    due           = refresh_gap >= cdd_pkg::RefreshMs;
    synced        = current_time >= cdd_pkg::SyncMin;
    zero          = target_time <= current_time;
    blink_flip    = zero && (blink_gap >= cdd_pkg::BlinkMs);
    blink_on_next = blink_on ^ blink_flip;
    push          = accept && due && synced;
    push_item.zero  = zero;
    push_item.shown = !zero || blink_on_next;
    push_item.left  = zero ? '0 : (target_time - current_time);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_time     <= '0;
      last_refresh_ms <= '0;
      last_blink_ms   <= '0;
      blink_on        <= 1'b0;
    end else begin
      if (cfg_valid) begin
        target_time <= cfg_data;
      end
      if (accept && due) begin
        last_refresh_ms <= now_ms;
      end
      if (push && blink_flip) begin
        blink_on      <= blink_on_next;
        last_blink_ms <= now_ms;
      end
    end
  end

endmodule

>>> hdl/cdd_queue.sv
// Short register queue between the front end and the back pipeline.
// Holds cdd_pkg::item_t entries; depends on cdd_pkg.
module cdd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cdd_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output cdd_pkg::item_t head,
  output logic           empty
);

  cdd_pkg::item_t                     slots [cdd_pkg::QueueDepth];
  logic [cdd_pkg::QueuePtrW-1:0]      wr_ptr;
  logic [cdd_pkg::QueuePtrW-1:0]      rd_ptr;
  logic [cdd_pkg::QueuePtrW:0]        count;

  assign full  = count == (cdd_pkg::QueuePtrW+1)'(cdd_pkg::QueueDepth);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/cdd_back.sv
// Back pipeline: splits the time left into days, hours, minutes, seconds and
// their decimal digits over six stages, the last being the output register.
// Depends on cdd_pkg.
module cdd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  cdd_pkg::item_t  q_head,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output cdd_pkg::digits_t out_digits,
  output logic            out_shown,
  output logic            out_zero
);

  logic en;

  // stage a: days
  logic        a_valid;
  logic [31:0] a_left;
  logic [15:0] a_days;
  logic        a_zero, a_shown;
  // stage b: remainder within a day, days saturated
  logic        b_valid;
  logic [16:0] b_rem;
  logic [6:0]  b_days;
  logic        b_zero, b_shown;
  // stage c: hours, day digits
  logic        c_valid;
  logic [16:0] c_rem;
  logic [4:0]  c_hours;
  logic [3:0]  c_dt, c_du;
  logic        c_zero, c_shown;
  // stage d: remainder within an hour, hour digits
  logic        d_valid;
  logic [11:0] d_rem;
  logic [3:0]  d_dt, d_du, d_hu;
  logic [1:0]  d_ht;
  logic        d_zero, d_shown;
  // stage e: minutes
  logic        e_valid;
  logic [11:0] e_rem;
  logic [5:0]  e_min;
  logic [3:0]  e_dt, e_du, e_hu;
  logic [1:0]  e_ht;
  logic        e_zero, e_shown;

  logic [50:0] day_prod;
  logic [32:0] day_back;
  logic [34:0] hour_prod;
  logic [16:0] hour_back;
  logic [24:0] min_prod;
  logic [11:0] min_back;
  logic [5:0]  sec_val;
  logic [3:0]  min_t, sec_t, c_dt_w;
  logic [4:0]  hour_less;
  logic [1:0]  hour_t;

  assign en    = !out_valid || out_ready;
  assign q_pop = en && !q_empty;

  always_comb begin
    day_prod  = 51'(q_head.left[31:7]) * 51'(cdd_pkg::DayRecip);
    day_back  = 33'(a_days) * 33'(cdd_pkg::DaySec);
    hour_prod = 35'(b_rem) * 35'(cdd_pkg::HourRecip);
    c_dt_w    = cdd_pkg::tens_of(b_days);
    hour_back = 17'(c_hours) * 17'(cdd_pkg::HourSec);
    if (c_hours >= 5'd20) begin
      hour_t    = 2'd2;
      hour_less = c_hours - 5'd20;
    end else if (c_hours >= 5'd10) begin
      hour_t    = 2'd1;
      hour_less = c_hours - 5'd10;
    end else begin
      hour_t    = 2'd0;
      hour_less = c_hours;
    end
    min_prod = 25'(d_rem) * 25'(cdd_pkg::MinRecip);
    min_back = 12'(e_min) * 12'(cdd_pkg::MinSec);
    sec_val  = 6'(e_rem - min_back);
    min_t    = cdd_pkg::tens_of(7'(e_min));
    sec_t    = cdd_pkg::tens_of(7'(sec_val));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      e_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_valid   <= !q_empty;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      e_valid   <= d_valid;
      out_valid <= e_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_left  <= q_head.left;
      a_days  <= day_prod[cdd_pkg::DayShift +: 16];
      a_zero  <= q_head.zero;
      a_shown <= q_head.shown;

      b_rem   <= 17'(a_left - day_back[31:0]);
      b_days  <= (a_days > 16'(cdd_pkg::DaysMax)) ? cdd_pkg::DaysMax : a_days[6:0];
      b_zero  <= a_zero;
      b_shown <= a_shown;

      c_rem   <= b_rem;
      c_hours <= hour_prod[cdd_pkg::HourShift +: 5];
      c_dt    <= c_dt_w;
      c_du    <= cdd_pkg::units_of(b_days, c_dt_w);
      c_zero  <= b_zero;
      c_shown <= b_shown;

      d_rem   <= 12'(c_rem - hour_back);
      d_dt    <= c_dt;
      d_du    <= c_du;
      d_ht    <= hour_t;
      d_hu    <= 4'(hour_less);
      d_zero  <= c_zero;
      d_shown <= c_shown;

      e_rem   <= d_rem;
      e_min   <= min_prod[cdd_pkg::MinShift +: 6];
      e_dt    <= d_dt;
      e_du    <= d_du;
      e_ht    <= d_ht;
      e_hu    <= d_hu;
      e_zero  <= d_zero;
      e_shown <= d_shown;

      out_digits.days_tens     <= e_dt;
      out_digits.days_units    <= e_du;
      out_digits.hours_tens    <= e_ht;
      out_digits.hours_units   <= e_hu;
      out_digits.minutes_tens  <= min_t[2:0];
      out_digits.minutes_units <= cdd_pkg::units_of(7'(e_min), min_t);
      out_digits.seconds_tens  <= sec_t[2:0];
      out_digits.seconds_units <= cdd_pkg::units_of(7'(sec_val), sec_t);
      out_shown <= e_shown;
      out_zero  <= e_zero;
    end
  end

endmodule

>>> hdl/countdown_dhms_digits.sv
// Top level of the countdown digit block: front end, queue and back pipeline.
// Depends on cdd_pkg, cdd_front, cdd_queue and cdd_back.
//
// Usage:
//   s_* carries ticks: s_tdata[31:0] now_ms, s_tdata[63:32] current_time.
//   A tick gives a result only when 1000 ms have passed since the last
//   refresh and current_time is at least 100000; other ticks are dropped
//   (a due but unsynchronized tick still restarts the 1000 ms interval).
//   m_* carries the eight digits in m_tdata and the flags in m_tuser.
//   cfg_* writes target_time; it is always ready, write it only while idle.
// Throughput: one tick per cycle while s_tready is high. An accepted tick is
// written into the four-entry queue, then runs through the six-stage divide
// pipeline with its three reciprocal multipliers to the output register.
// When m_tready is low the back pipeline holds and the queue fills; s_tready
// falls only once the queue is full.
// Reset clears target_time, the refresh and blink state, the queue and all
// pipeline valid bits; no result is pending after reset.
module countdown_dhms_digits (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // now_ms[31:0], current_time[63:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  // days_tens[3:0], days_units[7:4], hours_tens[9:8], hours_units[13:10],
  // minutes_tens[16:14], minutes_units[20:17], seconds_tens[23:21],
  // seconds_units[27:24], zero fill [31:28]
  output logic [31:0] m_tdata,
  output logic [1:0]  m_tuser,   // digits_shown[0], at_target[1]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic             push;
  cdd_pkg::item_t   push_item;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  cdd_pkg::item_t   q_head;
  cdd_pkg::digits_t digits;
  logic             shown;
  logic             zero;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;

  cdd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .in_valid     (s_tvalid),
    .now_ms       (s_tdata[31:0]),
    .current_time (s_tdata[63:32]),
    .in_ready     (s_tready),
    .push         (push),
    .push_item    (push_item)
  );

  cdd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  cdd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_digits (digits),
    .out_shown  (shown),
    .out_zero   (zero)
  );

  assign m_tdata = {4'b0000, digits};
  assign m_tuser = {zero, shown};

endmodule

>>> hdl/cdd_checker.sv
// Port-level checks of the countdown digit block, bound to its top level.
// Depends only on the ports of countdown_dhms_digits.
module cdd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result right after reset");

  // digits are always visible before the target
  a_shown_before: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tuser[0])
    else $error("digits hidden before target");

  a_zero_digits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata == 32'd0)
    else $error("nonzero digits at target");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= 4'd9 && m_tdata[7:4] <= 4'd9 &&
                 m_tdata[9:8] <= 2'd2 && m_tdata[13:10] <= 4'd9 &&
                 m_tdata[16:14] <= 3'd5 && m_tdata[20:17] <= 4'd9 &&
                 m_tdata[23:21] <= 3'd5 && m_tdata[27:24] <= 4'd9 &&
                 m_tdata[31:28] == 4'd0)
    else $error("digit out of range");

endmodule

bind countdown_dhms_digits cdd_checker u_cdd_checker (.*);

>>> test/countdown_dhms_digits_tb.sv
// Self-checking testbench for countdown_dhms_digits: a directed tick table and then
// random tick runs, checked against a cycle-free countdown predictor.
// Depends on cdd_pkg and countdown_dhms_digits.
`timescale 1ns / 100ps

module countdown_dhms_digits_tb;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned HoldCycles = 200;

  typedef struct packed {
    cdd_pkg::digits_t dg;
    logic             shown;
    logic             at_tgt;
  } countdown_t;

  typedef struct packed {
    logic       pinned;
    countdown_t res;
  } pin_t;

  typedef enum logic {ROW_TICK, ROW_TARGET} row_kind_t;

  // On a ROW_TARGET row now_ms holds the new target
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] now_ms;
    logic [31:0] wall;
    logic        pinned;
    countdown_t  res;
  } dir_row_t;

  // Digit packing, high to low: su, st, mu, mt, hu, ht, du, dt, shown, at_target
  localparam dir_row_t DirRows [21] = '{
    '{ROW_TICK, 32'd0, 32'd200000, 1'b0, 30'd0},          // too soon after reset
    '{ROW_TICK, 32'd999, 32'd200000, 1'b0, 30'd0},
    '{ROW_TICK, 32'd1000, 32'd99999, 1'b0, 30'd0},        // due, clock not synced
    '{ROW_TICK, 32'd1999, 32'd200000, 1'b0, 30'd0},
    '{ROW_TICK, 32'd2000, 32'd100000, 1'b1, {28'd0, 1'b1, 1'b1}},
    '{ROW_TICK, 32'd3000, 32'hFFFF_FFFF, 1'b1, {28'd0, 1'b0, 1'b1}},
    '{ROW_TICK, 32'h8000_0BB8, 32'd0, 1'b0, 30'd0},       // move refresh mark halfway
    '{ROW_TICK, 32'd3100, 32'd100000, 1'b1, {28'd0, 1'b0, 1'b1}},  // blink held
    '{ROW_TICK, 32'hFFFF_FF00, 32'd100000, 1'b0, 30'd0},
    '{ROW_TICK, 32'h0000_00FF, 32'd100000, 1'b0, 30'd0},  // too soon across wrap
    '{ROW_TICK, 32'h0000_02E8, 32'd100000, 1'b0, 30'd0},  // exactly 1000 across wrap
    '{ROW_TARGET, 32'hFFFF_FFFF, 32'd0, 1'b0, 30'd0},
    '{ROW_TICK, 32'd10000, 32'd100000, 1'b0, 30'd0},
    '{ROW_TICK, 32'd11000, 32'hFFFF_FFFE, 1'b1, {4'd1, 24'd0, 1'b1, 1'b0}},
    '{ROW_TICK, 32'd12000, 32'hFFFF_FFFF, 1'b0, 30'd0},
    '{ROW_TARGET, 32'd8839999, 32'd0, 1'b0, 30'd0},
    '{ROW_TICK, 32'd13000, 32'd200000, 1'b1,
      {4'd9, 3'd5, 4'd9, 3'd5, 4'd3, 2'd2, 4'd9, 4'd9, 1'b1, 1'b0}},
    '{ROW_TICK, 32'd14000, 32'd200001, 1'b0, 30'd0},
    '{ROW_TICK, 32'd15000, 32'd199999, 1'b0, 30'd0},      // 100 days, saturates
    '{ROW_TICK, 32'd16000, 32'd8839998, 1'b0, 30'd0},
    '{ROW_TICK, 32'd17000, 32'd8840004, 1'b0, 30'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  // Countdown state mirrored from the block
  logic [31:0] target_sec = '0;
  logic [31:0] refresh_mark = '0;
  logic [31:0] blink_mark = '0;
  logic        blink_lit = 1'b0;

  countdown_t  digits_due[$];
  pin_t        pinned_due[$];
  int unsigned bad_count = 0;
  int unsigned cycle_count = 0;
  bit          calm_run = 1'b0;
  bit          hold_req = 1'b0;

  countdown_dhms_digits dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic bit advance_countdown(input logic [31:0] now, input logic [31:0] wall,
                                           output countdown_t r);
    longint unsigned left;
    longint unsigned d, h, m, s;
    bit zero;
    r = '0;
    if (32'(now - refresh_mark) < cdd_pkg::RefreshMs) return 1'b0;
    refresh_mark = now;
    if (wall < cdd_pkg::SyncMin) return 1'b0;
    zero = (target_sec <= wall);
    if (zero) begin
      left = 0;
      if (32'(now - blink_mark) >= cdd_pkg::BlinkMs) begin
        blink_lit = ~blink_lit;
        blink_mark = now;
      end
    end else begin
      left = longint'(target_sec) - longint'(wall);
    end
    d = left / cdd_pkg::DaySec;
    h = (left % cdd_pkg::DaySec) / cdd_pkg::HourSec;
    m = (left % cdd_pkg::HourSec) / cdd_pkg::MinSec;
    s = left % cdd_pkg::MinSec;
    if (d > cdd_pkg::DaysMax) d = cdd_pkg::DaysMax;
    r.dg.days_tens = 4'(d / 10);
    r.dg.days_units = 4'(d % 10);
    r.dg.hours_tens = 2'(h / 10);
    r.dg.hours_units = 4'(h % 10);
    r.dg.minutes_tens = 3'(m / 10);
    r.dg.minutes_units = 4'(m % 10);
    r.dg.seconds_tens = 3'(s / 10);
    r.dg.seconds_units = 4'(s % 10);
    r.shown = ~zero | blink_lit;
    r.at_tgt = zero;
    return 1'b1;
  endfunction

  function automatic void cmp(input string what, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      bad_count++;
    end
  endfunction

  // A wall clock at or past the target that is also synchronized
  function automatic logic [31:0] past_wall(input logic [31:0] tgt);
    longint unsigned w;
    w = longint'(tgt < cdd_pkg::SyncMin ? cdd_pkg::SyncMin : tgt) + $urandom_range(0, 5);
    if (w > 64'hFFFF_FFFF) w = 64'hFFFF_FFFF;
    return 32'(w);
  endfunction

  // Predict on every input transfer, check on every output transfer
  always @(posedge clk) begin
    countdown_t       want;
    pin_t             pin;
    cdd_pkg::digits_t seen;
    bit               due;
    if (!rst) begin
      if (cfg_valid && cfg_ready) target_sec = cfg_data;
      if (s_tvalid && s_tready) begin
        pin = pinned_due.pop_front();
        due = advance_countdown(s_tdata[31:0], s_tdata[63:32], want);
        if (pin.pinned) digits_due.push_back(pin.res);
        else if (due) digits_due.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (digits_due.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h/%b",
                   $time, m_tdata, m_tuser);
          bad_count++;
        end else begin
          want = digits_due.pop_front();
          seen = m_tdata[27:0];
          cmp("days_tens", want.dg.days_tens, seen.days_tens);
          cmp("days_units", want.dg.days_units, seen.days_units);
          cmp("hours_tens", want.dg.hours_tens, seen.hours_tens);
          cmp("hours_units", want.dg.hours_units, seen.hours_units);
          cmp("minutes_tens", want.dg.minutes_tens, seen.minutes_tens);
          cmp("minutes_units", want.dg.minutes_units, seen.minutes_units);
          cmp("seconds_tens", want.dg.seconds_tens, seen.seconds_tens);
          cmp("seconds_units", want.dg.seconds_units, seen.seconds_units);
          cmp("zero fill", 0, m_tdata[31:28]);
          cmp("digits_shown", want.shown, m_tuser[0]);
          cmp("at_target", want.at_tgt, m_tuser[1]);
        end
      end
    end
  end

  task automatic send_tick(input logic [31:0] now, input logic [31:0] wall,
                           input logic pinned, input countdown_t res);
    if (!calm_run && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    pinned_due.push_back('{pinned, res});
    s_tvalid <= 1'b1;
    s_tdata <= {wall, now};
    do @(posedge clk); while (!s_tready);
  endtask

  // Write the target only once every pending result is out and the front is quiet
  task automatic load_target(input logic [31:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (digits_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: random ready bursts, one long hold-off on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else if (calm_run) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned spans [5];
    logic [31:0] base_ms;
    logic [31:0] now;
    logic [31:0] wall;
    logic [31:0] tgt;
    longint      lw;
    int unsigned r;
    int unsigned q;
    spans = '{60, 4000, 90000, 9000000, 32'hFFFF_FFFF};
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DirRows[i]) begin
      if (DirRows[i].kind == ROW_TARGET) load_target(DirRows[i].now_ms);
      else send_tick(DirRows[i].now_ms, DirRows[i].wall, DirRows[i].pinned, DirRows[i].res);
    end
    base_ms = 32'd17000;

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: tgt = '0;
        1: tgt = '1;
        2: tgt = cdd_pkg::SyncMin;
        default: tgt = $urandom_range(32'hFFFF_FFFF, cdd_pkg::SyncMin);
      endcase
      load_target(tgt);
      calm_run = (ph >= 6);
      if (ph == 4) hold_req = 1'b1;
      for (int i = 0; i < 130; i++) begin
        r = $urandom_range(0, 99);
        q = $urandom_range(0, 99);
        if (q < 55) begin
          lw = longint'(tgt) - longint'($urandom_range(1, spans[ph % 5]));
          wall = (lw < 0) ? $urandom : 32'(lw);
        end else if (q < 75) begin
          wall = past_wall(tgt);
        end else if (q < 85) begin
          wall = $urandom_range(0, cdd_pkg::SyncMin - 1);
        end else begin
          wall = $urandom;
        end
        if (r < 70) begin
          now = base_ms + $urandom_range(1000, 1500);
        end else if (r < 82) begin
          now = base_ms + $urandom_range(0, 999);
        end else if (r < 88) begin
          now = $urandom;
        end else if (r < 93) begin
          // toggle at zero, push the refresh mark half a wrap away, then come back
          // close to the toggle so the blink interval decides alone
          send_tick(base_ms + 1000, past_wall(tgt), 1'b0, '0);
          send_tick(base_ms + 1000 + 32'h8000_0000, $urandom, 1'b0, '0);
          now = base_ms + 1000 + $urandom_range(0, 999);
          wall = past_wall(tgt);
        end else begin
          now = base_ms + cdd_pkg::RefreshMs;
        end
        send_tick(now, wall, 1'b0, '0);
        base_ms = now;
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (digits_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (bad_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/cdd_pkg.sv
hdl/cdd_front.sv
hdl/cdd_queue.sv
hdl/cdd_back.sv
hdl/countdown_dhms_digits.sv
hdl/cdd_checker.sv
test/countdown_dhms_digits_tb.sv
